FILE: hdl/pls_pkg.sv
`default_nettype none
package pls_pkg;

  // default history size
  localparam int unsigned HistoryDepth = 4096;

  // register indexes
  localparam logic [2:0] CfgMatchRadius   = 3'd0;
  localparam logic [2:0] CfgSkipCount     = 3'd1;
  localparam logic [2:0] CfgMaxCovX       = 3'd2;
  localparam logic [2:0] CfgMaxCovY       = 3'd3;
  localparam logic [2:0] CfgMaxCovHeading = 3'd4;

  // distance cap of 1000 square meters in Q32.32
  localparam logic [42:0] DistCap = 43'd1000 << 32;

  // quotient width of the covariance division
  localparam int unsigned DivW = 45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MULX,
    ST_DIVX,
    ST_MULY,
    ST_DIVY,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

FILE: hdl/pose_loop_closure_search.sv
// flow: a pose without a search goes straight to the result; with a search the older
//   entries are scanned, then the two covariance divisions run when a match is found
// throughput: one pose at a time; the scan reads one history entry per cycle from
//   the pose memory, the divider retires one quotient bit per cycle
// reset: registers return to their reset values, stored count clears, memory not cleared
`default_nettype none
module pose_loop_closure_search #(
  parameter int unsigned HISTORY_DEPTH = pls_pkg::HistoryDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i,
  input  wire logic        pose_valid_i,
  output logic             pose_stall_o,
  input  wire logic signed [31:0] pose_x_i,
  input  wire logic signed [31:0] pose_y_i,
  input  wire logic signed [18:0] pose_heading_i,
  output logic             result_valid_o,
  input  wire logic        result_stall_i,
  output logic             match_found_o,
  output logic [11:0]      match_index_o,
  output logic [11:0]      current_index_o,
  output logic signed [19:0] heading_delta_o,
  output logic [23:0]      cov_x_o,
  output logic [23:0]      cov_y_o,
  output logic [23:0]      cov_heading_o,
  output logic             history_overflow_o
);
  import pls_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned XW = ((AW > 12) ? AW : 12) + 1;
  localparam int unsigned MW = 32 + 32 + 19;

  // configuration registers
  logic [22:0] radius_q;
  logic [11:0] skip_q;
  logic [23:0] covx_q, covy_q, covh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 23'd655;
      skip_q   <= 12'd300;
      covx_q   <= 24'd65536;
      covy_q   <= 24'd65536;
      covh_q   <= 24'd65536;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgMatchRadius:   radius_q <= cfg_data_i[22:0];
        CfgSkipCount:     skip_q   <= cfg_data_i[11:0];
        CfgMaxCovX:       covx_q   <= cfg_data_i;
        CfgMaxCovY:       covy_q   <= cfg_data_i;
        CfgMaxCovHeading: covh_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;

  logic [CW-1:0] cnt_q;
  logic [AW-1:0] cur_idx_q, end_q, rd_addr_q;
  logic signed [31:0] cur_x_q, cur_y_q;
  logic signed [18:0] cur_h_q;
  logic [42:0] limit_q;
  logic overflow_q;

  logic in_xfer, out_free, full, do_search, last_rd;
  logic [XW-1:0] idx_x, skip_x, end_x;
  logic [45:0] r2;
  logic [42:0] limit_d;

  assign pose_stall_o = (state_q != ST_IDLE);
  assign in_xfer      = pose_valid_i && !pose_stall_o;
  assign out_free     = !result_valid_o || !result_stall_i;
  assign full         = (cnt_q >= CW'(HISTORY_DEPTH));
  assign idx_x        = XW'(cnt_q[AW-1:0]);
  assign skip_x       = XW'(skip_q);
  assign end_x        = idx_x - skip_x;
  assign do_search    = !full && (idx_x > skip_x);
  assign last_rd      = (rd_addr_q == end_q - AW'(1));
  assign r2           = 46'(radius_q) * 46'(radius_q);
  assign limit_d      = (r2 > 46'(DistCap)) ? DistCap : r2[42:0];

  // pose memory
  logic [MW-1:0] mem [HISTORY_DEPTH];
  logic [MW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer && !full) begin
      mem[cnt_q[AW-1:0]] <= {pose_x_i, pose_y_i, pose_heading_i};
    end
    rd_q <= mem[rd_addr_q];
  end

  // scan pipeline
  logic v1_q, v2_q, v3_q;
  logic [AW-1:0] i1_q, i2_q, i3_q;
  logic ok2_q, ok3_q;
  logic [20:0] dxa2_q, dya2_q, dxa3_q, dya3_q;
  logic signed [18:0] h2_q, h3_q;
  logic [41:0] dx2_q, dy2_q;

  logic signed [32:0] dx, dy;
  logic [32:0] adx, ady;
  logic [42:0] dsum;
  logic better;
  logic issue;

  assign issue = (state_q == ST_SCAN);
  assign dx  = {rd_q[MW-1], rd_q[MW-1 -: 32]} - {cur_x_q[31], cur_x_q};
  assign dy  = {rd_q[50], rd_q[50:19]} - {cur_y_q[31], cur_y_q};
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);
  assign dsum = 43'(dx2_q) + 43'(dy2_q);

  logic found_q;
  logic [AW-1:0] best_idx_q;
  logic [42:0] best_d_q;
  logic [20:0] best_dx_q, best_dy_q;
  logic signed [18:0] best_h_q;

  assign better = v3_q && ok3_q && (43'(dx2_q) < limit_q) && (43'(dy2_q) < limit_q)
                  && (dsum < limit_q) && (!found_q || dsum < best_d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    i1_q   <= rd_addr_q;
    i2_q   <= i1_q;
    ok2_q  <= (adx[32:21] == '0) && (ady[32:21] == '0);
    dxa2_q <= adx[20:0];
    dya2_q <= ady[20:0];
    h2_q   <= rd_q[18:0];
    i3_q   <= i2_q;
    ok3_q  <= ok2_q;
    dxa3_q <= dxa2_q;
    dya3_q <= dya2_q;
    h3_q   <= h2_q;
    dx2_q  <= 42'(dxa2_q) * 42'(dxa2_q);
    dy2_q  <= 42'(dya2_q) * 42'(dya2_q);
  end

  // covariance divider, one quotient bit per cycle
  logic [DivW-1:0] quo_q;
  logic [22:0] rem_q;
  logic [5:0] step_q;
  logic [23:0] trial;
  logic ge, div_last;
  logic [23:0] quo_sat;
  logic [23:0] cx_q;

  assign trial    = {rem_q, quo_q[DivW-1]};
  assign ge       = (trial >= 24'(radius_q));
  assign div_last = (step_q == 6'(DivW - 1));
  assign quo_sat  = (quo_q[DivW-1:24] != '0) ? 24'hFFFFFF : quo_q[23:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_xfer) state_d = do_search ? ST_SCAN : ST_DONE;
      ST_SCAN:  if (last_rd) state_d = ST_DRAIN;
      ST_DRAIN: if (!v1_q && !v2_q && !v3_q) state_d = found_q ? ST_MULX : ST_DONE;
      ST_MULX:  state_d = ST_DIVX;
      ST_DIVX:  if (div_last) state_d = ST_MULY;
      ST_MULY:  state_d = ST_DIVY;
      ST_DIVY:  if (div_last) state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rd_addr_q <= '0;
      found_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        rd_addr_q <= '0;
        found_q   <= 1'b0;
        if (!full) cnt_q <= cnt_q + CW'(1);
      end else if (issue) begin
        rd_addr_q <= rd_addr_q + AW'(1);
      end
      if (better) found_q <= 1'b1;
    end
  end

  // per item payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cur_x_q    <= pose_x_i;
      cur_y_q    <= pose_y_i;
      cur_h_q    <= pose_heading_i;
      cur_idx_q  <= full ? AW'(HISTORY_DEPTH - 1) : cnt_q[AW-1:0];
      end_q      <= end_x[AW-1:0];
      limit_q    <= limit_d;
      overflow_q <= full;
    end
    if (better) begin
      best_idx_q <= i3_q;
      best_d_q   <= dsum;
      best_dx_q  <= dxa3_q;
      best_dy_q  <= dya3_q;
      best_h_q   <= h3_q;
    end
    case (state_q)
      ST_MULX: begin
        quo_q  <= DivW'(covx_q) * DivW'(best_dx_q);
        rem_q  <= '0;
        step_q <= '0;
      end
      ST_MULY: begin
        quo_q  <= DivW'(covy_q) * DivW'(best_dy_q);
        rem_q  <= '0;
        step_q <= '0;
        cx_q   <= quo_sat;
      end
      ST_DIVX, ST_DIVY: begin
        quo_q  <= {quo_q[DivW-2:0], ge};
        rem_q  <= ge ? 23'(trial - 24'(radius_q)) : trial[22:0];
        step_q <= step_q + 6'd1;
      end
      default: ;
    endcase
  end

  // result register
  logic out_load;
  logic [XW+11:0] cur_ext, best_ext;
  assign out_load = (state_q == ST_DONE) && out_free;
  assign cur_ext  = (XW+12)'(cur_idx_q);
  assign best_ext = (XW+12)'(best_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else if (out_load) begin
      result_valid_o <= 1'b1;
    end else if (!result_stall_i) begin
      result_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      match_found_o      <= found_q;
      match_index_o      <= found_q ? best_ext[11:0] : 12'd0;
      current_index_o    <= cur_ext[11:0];
      heading_delta_o    <= found_q ? (20'(cur_h_q) - 20'(best_h_q)) : 20'sd0;
      cov_x_o            <= found_q ? cx_q : 24'd0;
      cov_y_o            <= found_q ? quo_sat : 24'd0;
      cov_heading_o      <= found_q ? covh_q : 24'd0;
      history_overflow_o <= overflow_q;
    end
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(HISTORY_DEPTH)) else $error("stored count beyond depth");
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !(v1_q || v2_q || v3_q)) else $error("scan pipeline busy in idle");
  a_mul_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MULX |-> found_q) else $error("division without a match");
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> rd_addr_q < end_q) else $error("scan read past end");

endmodule
`default_nettype wire

FILE: dv/pose_result_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module pose_result_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [23:0]        cfg_data_i,
  input  wire logic               pose_valid_i,
  input  wire logic               pose_stall_i,
  input  wire logic signed [31:0] pose_x_i,
  input  wire logic signed [31:0] pose_y_i,
  input  wire logic signed [18:0] pose_heading_i,
  input  wire logic               result_valid_i,
  input  wire logic               result_stall_i,
  input  wire logic               match_found_i,
  input  wire logic [11:0]        match_index_i,
  input  wire logic [11:0]        current_index_i,
  input  wire logic signed [19:0] heading_delta_i,
  input  wire logic [23:0]        cov_x_i,
  input  wire logic [23:0]        cov_y_i,
  input  wire logic [23:0]        cov_heading_i,
  input  wire logic               history_overflow_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      match_count_o,
  output int                      overflow_count_o
);
  import pls_pkg::*;

  typedef struct packed {
    logic        found;
    logic [11:0] match_index;
    logic [11:0] current_index;
    logic [19:0] heading_delta;
    logic [23:0] cov_x;
    logic [23:0] cov_y;
    logic [23:0] cov_heading;
    logic        overflow;
  } closure_t;

  // shadow of the pose history and registers
  logic signed [31:0] hist_x [HistoryDepth];
  logic signed [31:0] hist_y [HistoryDepth];
  logic signed [18:0] hist_hd [HistoryDepth];
  int unsigned        stored;
  logic [22:0]        radius;
  logic [11:0]        skip;
  logic [23:0]        cov_x_max;
  logic [23:0]        cov_y_max;
  logic [23:0]        cov_hd_max;

  closure_t closure_q [$];

  assign pending_o = closure_q.size();

  function automatic logic [63:0] abs_delta(logic signed [31:0] a, logic signed [31:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? 64'(-d) : 64'(d);
  endfunction

  function automatic logic [23:0] scaled_cov(logic [23:0] cmax, logic [63:0] diff);
    logic [63:0] q;
    if (radius == 0) return '0;
    q = (64'(cmax) * diff) / 64'(radius);
    return (q > 64'hFFFFFF) ? 24'hFFFFFF : q[23:0];
  endfunction

  // store the pose and search the older history for the nearest partner
  function automatic closure_t search_closure(logic signed [31:0] x, logic signed [31:0] y,
                                              logic signed [18:0] h);
    closure_t    r;
    int unsigned idx;
    int unsigned best;
    logic        found;
    logic [63:0] lim;
    logic [63:0] best_d;
    logic [63:0] dx2;
    logic [63:0] dy2;
    logic [63:0] dx;
    logic [63:0] dy;
    r = '0;
    if (stored >= HistoryDepth) begin
      r.current_index = 12'(HistoryDepth - 1);
      r.overflow = 1'b1;
      return r;
    end
    idx = stored;
    hist_x[idx] = x;
    hist_y[idx] = y;
    hist_hd[idx] = h;
    stored = idx + 1;
    lim = 64'(radius) * 64'(radius);
    if (lim > 64'(DistCap)) lim = 64'(DistCap);
    found = 1'b0;
    best = 0;
    best_d = '0;
    if (idx >= skip) begin
      for (int unsigned i = 0; i < idx - skip; i++) begin
        dx = abs_delta(hist_x[i], x);
        dy = abs_delta(hist_y[i], y);
        dx2 = dx * dx;
        dy2 = dy * dy;
        if (dx2 < lim && dy2 < lim && dx2 + dy2 < lim && (!found || dx2 + dy2 < best_d)) begin
          found = 1'b1;
          best = i;
          best_d = dx2 + dy2;
        end
      end
    end
    r.current_index = 12'(idx);
    if (found) begin
      r.found = 1'b1;
      r.match_index = 12'(best);
      r.heading_delta = 20'(int'(h) - int'(hist_hd[best]));
      r.cov_x = scaled_cov(cov_x_max, abs_delta(hist_x[best], x));
      r.cov_y = scaled_cov(cov_y_max, abs_delta(hist_y[best], y));
      r.cov_heading = cov_hd_max;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected %0h actual %0h", name, exp, act);
      fail_count_o++;
    end
  endtask

  // watch config writes, pose transfers and result transfers
  always @(posedge clk_i or negedge rst_ni) begin
    closure_t e;
    if (!rst_ni) begin
      stored = 0;
      radius = 23'd655;
      skip = 12'd300;
      cov_x_max = 24'd65536;
      cov_y_max = 24'd65536;
      cov_hd_max = 24'd65536;
      closure_q.delete();
      fail_count_o = 0;
      match_count_o = 0;
      overflow_count_o = 0;
    end else begin
      if (result_valid_i && !result_stall_i) begin
        if (closure_q.size() == 0) begin
          $error("result transfer with no pose pending");
          fail_count_o++;
        end else begin
          e = closure_q.pop_front();
          check_field("match_found", e.found, match_found_i);
          check_field("match_index", e.match_index, match_index_i);
          check_field("current_index", e.current_index, current_index_i);
          check_field("heading_delta", e.heading_delta, $unsigned(heading_delta_i));
          check_field("cov_x", e.cov_x, cov_x_i);
          check_field("cov_y", e.cov_y, cov_y_i);
          check_field("cov_heading", e.cov_heading, cov_heading_i);
          check_field("history_overflow", e.overflow, history_overflow_i);
          if (e.found) match_count_o++;
          if (e.overflow) overflow_count_o++;
        end
      end
      if (pose_valid_i && !pose_stall_i)
        closure_q.insert(closure_q.size(),
                         search_closure(pose_x_i, pose_y_i, pose_heading_i));
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgMatchRadius:   radius = cfg_data_i[22:0];
          CfgSkipCount:     skip = cfg_data_i[11:0];
          CfgMaxCovX:       cov_x_max = cfg_data_i;
          CfgMaxCovY:       cov_y_max = cfg_data_i;
          CfgMaxCovHeading: cov_hd_max = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import pls_pkg::*;

  localparam int CycleLimit = 3000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;
  logic               pose_valid = 1'b0;
  logic               pose_stall;
  logic signed [31:0] pose_x = '0;
  logic signed [31:0] pose_y = '0;
  logic signed [18:0] pose_heading = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic               match_found;
  logic [11:0]        match_index;
  logic [11:0]        current_index;
  logic signed [19:0] heading_delta;
  logic [23:0]        cov_x;
  logic [23:0]        cov_y;
  logic [23:0]        cov_heading;
  logic               history_overflow;
  int                 fail_count;
  int                 pending;
  int                 match_count;
  int                 overflow_count;

  int          tx_idle_pct = 27;
  int          rx_stall_pct = 57;
  int          cycles = 0;
  int          poses_sent = 0;
  int          cur_radius = 655;
  logic [31:0] center_x [4];
  logic [31:0] center_y [4];

  always #10 clk_i = ~clk_i;

  pose_loop_closure_search u_top (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .pose_valid_i(pose_valid), .pose_stall_o(pose_stall),
    .pose_x_i(pose_x), .pose_y_i(pose_y), .pose_heading_i(pose_heading),
    .result_valid_o(result_valid), .result_stall_i(result_stall),
    .match_found_o(match_found), .match_index_o(match_index),
    .current_index_o(current_index), .heading_delta_o(heading_delta),
    .cov_x_o(cov_x), .cov_y_o(cov_y), .cov_heading_o(cov_heading),
    .history_overflow_o(history_overflow)
  );

  pose_result_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .pose_valid_i(pose_valid), .pose_stall_i(pose_stall),
    .pose_x_i(pose_x), .pose_y_i(pose_y), .pose_heading_i(pose_heading),
    .result_valid_i(result_valid), .result_stall_i(result_stall),
    .match_found_i(match_found), .match_index_i(match_index),
    .current_index_i(current_index), .heading_delta_i(heading_delta),
    .cov_x_i(cov_x), .cov_y_i(cov_y), .cov_heading_i(cov_heading),
    .history_overflow_i(history_overflow),
    .fail_count_o(fail_count), .pending_o(pending),
    .match_count_o(match_count), .overflow_count_o(overflow_count)
  );

  // receiver stalls
  always @(negedge clk_i)
    result_stall <= ($urandom_range(99) < rx_stall_pct);

  // run time limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("pose_loop_closure_search verification failed");
      $finish;
    end
  end

  // one pose transfer, with random idle cycles ahead of it
  task automatic send_pose(logic [31:0] x, logic [31:0] y, int h);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      pose_valid <= 1'b0;
      @(negedge clk_i);
    end
    pose_valid <= 1'b1;
    pose_x <= x;
    pose_y <= y;
    pose_heading <= 19'(h);
    do @(posedge clk_i); while (pose_stall);
    poses_sent++;
  endtask

  task automatic drain_results();
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  // wait for idle, then load all registers
  task automatic configure(int rad, int skip, int cx, int cy, int ch);
    @(negedge clk_i);
    pose_valid <= 1'b0;
    drain_results();
    write_reg(CfgMatchRadius, 24'(rad));
    write_reg(CfgSkipCount, 24'(skip));
    write_reg(CfgMaxCovX, 24'(cx));
    write_reg(CfgMaxCovY, 24'(cy));
    write_reg(CfgMaxCovHeading, 24'(ch));
    @(negedge clk_i);
    cfg_we <= 1'b0;
    cur_radius = rad;
    for (int i = 0; i < 4; i++) begin
      center_x[i] = $urandom;
      center_y[i] = $urandom;
    end
  endtask

  function automatic int rand_heading();
    return int'($urandom_range(411776)) - 205888;
  endfunction

  // mostly poses clustered near a few places, some noise and exact repeats
  task automatic random_poses(int n);
    int          sel;
    int          span;
    int          c;
    logic [31:0] px;
    logic [31:0] py;
    px = $urandom;
    py = $urandom;
    span = (cur_radius > (1 << 23)) ? (1 << 24) : 2 * cur_radius;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      c = $urandom_range(3);
      if (sel < 70) begin
        px = center_x[c] + 32'(int'($urandom_range(2 * span)) - span);
        py = center_y[c] + 32'(int'($urandom_range(2 * span)) - span);
      end else if (sel < 90) begin
        px = $urandom;
        py = $urandom;
      end
      send_pose(px, py, rand_heading());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: ties, the radius edge, extreme positions and headings
    configure(262144, 0, 65536, 16777215, 0);
    send_pose(0, 0, 0);
    send_pose(0, 0, 0);
    send_pose(100, -100, 205888);
    send_pose(262144, 0, -205888);
    send_pose(32'h7fffffff, 32'h7fffffff, 205888);
    send_pose(32'h80000000, 32'h80000000, -205888);
    send_pose(32'h80000000, 32'h7fffffff, 1);
    send_pose(32'h7fffffff, 32'h80000000, -1);
    send_pose(32'h80000000, 32'h80000000, 205888);
    send_pose(32'h7fffffff, 32'h7fffffff, -205888);
    send_pose(262143, 1, 12345);
    configure(8388607, 3, 16777215, 0, 16777215);
    send_pose(32'h00100000, 32'hfff00000, 7);
    send_pose(0, 0, -7);
    send_pose(32'h00100000, 32'hfff00000, 100);
    send_pose(32'h00200000, 32'h00200000, -100);
    send_pose(1, -1, 205888);
    configure(1, 0, 16777215, 16777215, 16777215);
    send_pose(0, 0, 0);
    send_pose(1, 0, 0);

    // random phases, receiver stalling heavy then sender idling heavy then none
    configure(2072430, 0, 65536, 65536, 65536);
    random_poses(20);
    configure(655, 2, $urandom_range(16777215), $urandom_range(16777215), 65536);
    random_poses(20);
    tx_idle_pct = 57;
    rx_stall_pct = 27;
    configure($urandom_range(8388607, 1), 1, 0, 16777215, $urandom_range(16777215));
    random_poses(20);
    configure(131072, 0, 16777215, 65536, 0);
    random_poses(22);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    configure(8388607, $urandom_range(5), 65536, 0, 65536);
    random_poses(20);
    configure(655, 0, 65536, 65536, 65536);
    random_poses(20);

    @(negedge clk_i);
    pose_valid <= 1'b0;
    drain_results();
    $display("sent %0d poses over nine register settings and three idling modes", poses_sent);
    $display("%0d loop closures found, %0d poses dropped on a full history",
             match_count, overflow_count);
    if (fail_count == 0) begin
      $display("pose_loop_closure_search verification clean");
    end else begin
      $display("pose_loop_closure_search verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
